/* rtl/core/s512_pkg.sv */
`timescale 1ns / 1ps

package s512_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } s512_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        length_error;
  } s512_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } s512_state_e;

  // control from the sequencer to the block buffer / schedule
  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       step;
  } s512_sched_ctl_t;

  localparam int unsigned NumRounds = 80;
  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [6:0]  LenStart  = 7'd112;

  localparam logic [7:0][63:0] InitHash = {
    64'h5BE0CD19137E2179, 64'h1F83D9ABFB41BD6B,
    64'h9B05688C2B3E6C1F, 64'h510E527FADE682D1,
    64'hA54FF53A5F1D36F1, 64'h3C6EF372FE94F82B,
    64'hBB67AE8584CAA73B, 64'h6A09E667F3BCC908
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] round_k(input logic [6:0] idx);
    logic [63:0] k;
    unique case (idx)
      7'd0:  k = 64'h428A2F98D728AE22;  7'd1:  k = 64'h7137449123EF65CD;
      7'd2:  k = 64'hB5C0FBCFEC4D3B2F;  7'd3:  k = 64'hE9B5DBA58189DBBC;
      7'd4:  k = 64'h3956C25BF348B538;  7'd5:  k = 64'h59F111F1B605D019;
      7'd6:  k = 64'h923F82A4AF194F9B;  7'd7:  k = 64'hAB1C5ED5DA6D8118;
      7'd8:  k = 64'hD807AA98A3030242;  7'd9:  k = 64'h12835B0145706FBE;
      7'd10: k = 64'h243185BE4EE4B28C;  7'd11: k = 64'h550C7DC3D5FFB4E2;
      7'd12: k = 64'h72BE5D74F27B896F;  7'd13: k = 64'h80DEB1FE3B1696B1;
      7'd14: k = 64'h9BDC06A725C71235;  7'd15: k = 64'hC19BF174CF692694;
      7'd16: k = 64'hE49B69C19EF14AD2;  7'd17: k = 64'hEFBE4786384F25E3;
      7'd18: k = 64'h0FC19DC68B8CD5B5;  7'd19: k = 64'h240CA1CC77AC9C65;
      7'd20: k = 64'h2DE92C6F592B0275;  7'd21: k = 64'h4A7484AA6EA6E483;
      7'd22: k = 64'h5CB0A9DCBD41FBD4;  7'd23: k = 64'h76F988DA831153B5;
      7'd24: k = 64'h983E5152EE66DFAB;  7'd25: k = 64'hA831C66D2DB43210;
      7'd26: k = 64'hB00327C898FB213F;  7'd27: k = 64'hBF597FC7BEEF0EE4;
      7'd28: k = 64'hC6E00BF33DA88FC2;  7'd29: k = 64'hD5A79147930AA725;
      7'd30: k = 64'h06CA6351E003826F;  7'd31: k = 64'h142929670A0E6E70;
      7'd32: k = 64'h27B70A8546D22FFC;  7'd33: k = 64'h2E1B21385C26C926;
      7'd34: k = 64'h4D2C6DFC5AC42AED;  7'd35: k = 64'h53380D139D95B3DF;
      7'd36: k = 64'h650A73548BAF63DE;  7'd37: k = 64'h766A0ABB3C77B2A8;
      7'd38: k = 64'h81C2C92E47EDAEE6;  7'd39: k = 64'h92722C851482353B;
      7'd40: k = 64'hA2BFE8A14CF10364;  7'd41: k = 64'hA81A664BBC423001;
      7'd42: k = 64'hC24B8B70D0F89791;  7'd43: k = 64'hC76C51A30654BE30;
      7'd44: k = 64'hD192E819D6EF5218;  7'd45: k = 64'hD69906245565A910;
      7'd46: k = 64'hF40E35855771202A;  7'd47: k = 64'h106AA07032BBD1B8;
      7'd48: k = 64'h19A4C116B8D2D0C8;  7'd49: k = 64'h1E376C085141AB53;
      7'd50: k = 64'h2748774CDF8EEB99;  7'd51: k = 64'h34B0BCB5E19B48A8;
      7'd52: k = 64'h391C0CB3C5C95A63;  7'd53: k = 64'h4ED8AA4AE3418ACB;
      7'd54: k = 64'h5B9CCA4F7763E373;  7'd55: k = 64'h682E6FF3D6B2B8A3;
      7'd56: k = 64'h748F82EE5DEFB2FC;  7'd57: k = 64'h78A5636F43172F60;
      7'd58: k = 64'h84C87814A1F0AB72;  7'd59: k = 64'h8CC702081A6439EC;
      7'd60: k = 64'h90BEFFFA23631E28;  7'd61: k = 64'hA4506CEBDE82BDE9;
      7'd62: k = 64'hBEF9A3F7B2C67915;  7'd63: k = 64'hC67178F2E372532B;
      7'd64: k = 64'hCA273ECEEA26619C;  7'd65: k = 64'hD186B8C721C0C207;
      7'd66: k = 64'hEADA7DD6CDE0EB1E;  7'd67: k = 64'hF57D4F7FEE6ED178;
      7'd68: k = 64'h06F067AA72176FBA;  7'd69: k = 64'h0A637DC5A2C898A6;
      7'd70: k = 64'h113F9804BEF90DAE;  7'd71: k = 64'h1B710B35131C471B;
      7'd72: k = 64'h28DB77F523047D84;  7'd73: k = 64'h32CAAB7B40C72493;
      7'd74: k = 64'h3C9EBE0A15C9BEBC;  7'd75: k = 64'h431D67C49C100D4C;
      7'd76: k = 64'h4CC5D4BECB3E42B6;  7'd77: k = 64'h597F299CFC657E2A;
      7'd78: k = 64'h5FCB6FAB3AD6FAEC;  7'd79: k = 64'h6C44198C4A475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/s512_sched.sv */
`timescale 1ns / 1ps

module s512_sched (
  input  logic                      clk_i,
  input  s512_pkg::s512_sched_ctl_t ctl_i,
  output logic [63:0]               w_o
);

  logic [1023:0] buf_q, buf_d;
  logic [63:0]   w1, w9, w14, w_new;

  assign w_o = buf_q[1023 -: 64];
  assign w1  = buf_q[1023 - 64 -: 64];
  assign w9  = buf_q[1023 - 9 * 64 -: 64];
  assign w14 = buf_q[1023 - 14 * 64 -: 64];

  assign w_new = (s512_pkg::rotr(w14, 19) ^ s512_pkg::rotr(w14, 61) ^ (w14 >> 6))
               + w9
               + (s512_pkg::rotr(w1, 1) ^ s512_pkg::rotr(w1, 8) ^ (w1 >> 7))
               + w_o;

  // bytes shift in at the bottom; a full block has byte 0 at the top
  always_comb begin
    buf_d = buf_q;
    if (ctl_i.push) begin
      buf_d = {buf_q[1015:0], ctl_i.push_byte};
    end else if (ctl_i.step) begin
      buf_d = {buf_q[959:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

/* rtl/core/s512_round.sv */
`timescale 1ns / 1ps

module s512_round (
  input  logic                   clk_i,
  input  logic                   load_i,
  input  logic [7:0][63:0]       chain_i,
  input  logic                   step_i,
  input  logic [6:0]             round_i,
  input  logic [63:0]            w_i,
  output logic [7:0][63:0]       work_o
);

  logic [7:0][63:0] work_q, work_d;
  logic [63:0] a, b, c, d, e, f, g, h, t1, t2;

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];
  assign e = work_q[4];
  assign f = work_q[5];
  assign g = work_q[6];
  assign h = work_q[7];

  assign t1 = h + (s512_pkg::rotr(e, 14) ^ s512_pkg::rotr(e, 18) ^ s512_pkg::rotr(e, 41))
            + ((e & f) ^ (~e & g)) + s512_pkg::round_k(round_i) + w_i;
  assign t2 = (s512_pkg::rotr(a, 28) ^ s512_pkg::rotr(a, 34) ^ s512_pkg::rotr(a, 39))
            + ((a & b) ^ (a & c) ^ (b & c));

  always_comb begin
    work_d = work_q;
    if (load_i) begin
      work_d = chain_i;
    end else if (step_i) begin
      work_d[0] = t1 + t2;
      work_d[1] = a;
      work_d[2] = b;
      work_d[3] = c;
      work_d[4] = d + t1;
      work_d[5] = e;
      work_d[6] = f;
      work_d[7] = g;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign work_o = work_q;

endmodule

/* rtl/core/sha512_hash_engine.sv */
`timescale 1ns / 1ps

// SHA-512 engine, one message byte per input beat. Bytes are taken one per
// cycle until a 128-byte block is full; the block is then compressed by one
// shared round unit over its 80 rounds, followed by the chaining add, and
// input is stalled meanwhile. A beat with last set pads the message one byte
// per cycle up to the length field (through an extra block when it does not
// fit), shifts in the 16 length bytes, compresses, and then presents the eight
// digest words as eight output beats, most significant first. The engine
// then returns to the initial hash values for the next message.

module sha512_hash_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  s512_pkg::s512_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output s512_pkg::s512_out_t out_data_o
);

  s512_pkg::s512_state_e state_q, state_d;

  logic [7:0][63:0] chain_q;
  logic [7:0][63:0] work;
  logic [6:0]       fill_q;
  logic [127:0]     cnt_q;
  logic [128:0]     cnt_sum;
  logic             ovf_q;
  logic             fin_q, pad80_q, len_done_q;
  logic [6:0]       rnd_q;
  logic [2:0]       idx_q;
  logic             out_valid_q;
  s512_pkg::s512_out_t out_q;
  logic [63:0]      w;

  logic accept, absorb, full, rnd_last, out_load, msg_done;
  s512_pkg::s512_sched_ctl_t sctl;

  assign accept   = (state_q == s512_pkg::ST_IDLE) && in_valid_i;
  assign absorb   = accept && in_data_i.byte_valid && !ovf_q;
  assign full     = sctl.push && (fill_q == 7'd127);
  assign rnd_last = (rnd_q == 7'(s512_pkg::NumRounds - 1));
  assign out_load = (state_q == s512_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);
  assign msg_done = out_load && (idx_q == 3'd7);
  assign cnt_sum  = {1'b0, cnt_q} + 129'd8;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      s512_pkg::ST_IDLE: begin
        if (accept) begin
          if (full) state_d = s512_pkg::ST_COMP;
          else if (in_data_i.last) state_d = s512_pkg::ST_PAD;
        end
      end
      s512_pkg::ST_PAD: begin
        if (full) state_d = s512_pkg::ST_COMP;
        else if (fill_q == s512_pkg::LenStart - 7'd1) state_d = s512_pkg::ST_LEN;
      end
      s512_pkg::ST_LEN: begin
        if (full) state_d = s512_pkg::ST_COMP;
      end
      s512_pkg::ST_COMP: begin
        if (rnd_last) state_d = s512_pkg::ST_ADD;
      end
      s512_pkg::ST_ADD: begin
        if (!fin_q) state_d = s512_pkg::ST_IDLE;
        else if (len_done_q) state_d = s512_pkg::ST_OUT;
        else state_d = s512_pkg::ST_PAD;
      end
      s512_pkg::ST_OUT: begin
        if (msg_done) state_d = s512_pkg::ST_IDLE;
      end
      default: state_d = s512_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sctl.push      = 1'b0;
    sctl.push_byte = in_data_i.data_byte;
    sctl.step      = 1'b0;
    unique case (state_q)
      s512_pkg::ST_IDLE: sctl.push = absorb;
      s512_pkg::ST_PAD: begin
        sctl.push      = 1'b1;
        sctl.push_byte = pad80_q ? 8'h00 : s512_pkg::PadByte;
      end
      s512_pkg::ST_LEN: begin
        sctl.push      = 1'b1;
        sctl.push_byte = cnt_q[127:120];
      end
      s512_pkg::ST_COMP: sctl.step = 1'b1;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != s512_pkg::ST_IDLE);

  s512_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sctl),
    .w_o   (w)
  );

  s512_round u_round (
    .clk_i   (clk_i),
    .load_i  (full),
    .chain_i (chain_q),
    .step_i  (sctl.step),
    .round_i (rnd_q),
    .w_i     (w),
    .work_o  (work)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= s512_pkg::ST_IDLE;
      chain_q     <= s512_pkg::InitHash;
      fill_q      <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      fin_q       <= 1'b0;
      pad80_q     <= 1'b0;
      len_done_q  <= 1'b0;
      rnd_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (sctl.push) fill_q <= fill_q + 7'd1;
      if (absorb) begin
        cnt_q <= cnt_sum[127:0];
        if (cnt_sum[128]) ovf_q <= 1'b1;
      end
      if (accept && in_data_i.last) fin_q <= 1'b1;
      if (state_q == s512_pkg::ST_PAD) pad80_q <= 1'b1;
      if (state_q == s512_pkg::ST_LEN) begin
        cnt_q <= {cnt_q[119:0], 8'h00};
        if (full) len_done_q <= 1'b1;
      end
      if (sctl.step) rnd_q <= rnd_last ? 7'd0 : rnd_q + 7'd1;
      if (state_q == s512_pkg::ST_ADD) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + work[i];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + 3'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // digest read out this cycle: start over for the next message
      if (msg_done) begin
        chain_q    <= s512_pkg::InitHash;
        cnt_q      <= '0;
        ovf_q      <= 1'b0;
        fin_q      <= 1'b0;
        pad80_q    <= 1'b0;
        len_done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.digest_word  <= chain_q[idx_q];
      out_q.word_index   <= idx_q;
      out_q.last_word    <= (idx_q == 3'd7);
      out_q.length_error <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sim/sha512_hash_engine_chk.sv */
`timescale 1ns / 1ps

module sha512_hash_engine_chk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  s512_pkg::s512_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  s512_pkg::s512_out_t out_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  digests_o,
  output int                  bytes_o
);

  localparam logic [63:0] RoundConst [0:79] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  logic [63:0]  hash_state [8];
  logic [7:0]   blk_bytes  [128];
  int           block_level;
  logic [127:0] msg_bits;
  logic         len_overflow;
  s512_pkg::s512_out_t digest_fifo [$];

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function void start_message();
    hash_state[0] = 64'h6A09E667F3BCC908; hash_state[1] = 64'hBB67AE8584CAA73B;
    hash_state[2] = 64'h3C6EF372FE94F82B; hash_state[3] = 64'hA54FF53A5F1D36F1;
    hash_state[4] = 64'h510E527FADE682D1; hash_state[5] = 64'h9B05688C2B3E6C1F;
    hash_state[6] = 64'h1F83D9ABFB41BD6B; hash_state[7] = 64'h5BE0CD19137E2179;
    block_level  = 0;
    msg_bits     = '0;
    len_overflow = 1'b0;
  endfunction

  function void compress_block();
    logic [63:0] sched [80];
    logic [63:0] v [8];
    logic [63:0] t1, t2;
    for (int i = 0; i < 16; i++) begin
      sched[i] = '0;
      for (int j = 0; j < 8; j++) sched[i] = {sched[i][55:0], blk_bytes[i*8+j]};
    end
    for (int i = 16; i < 80; i++) begin
      sched[i] = (ror64(sched[i-2], 19) ^ ror64(sched[i-2], 61) ^ (sched[i-2] >> 6))
               + sched[i-7] + sched[i-16]
               + (ror64(sched[i-15], 1) ^ ror64(sched[i-15], 8) ^ (sched[i-15] >> 7));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 80; i++) begin
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + sched[i];
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    block_level = 0;
  endfunction

  // absorb one input beat, queue the digest when it ends the message
  function void absorb_beat(input s512_pkg::s512_in_t beat);
    s512_pkg::s512_out_t w;
    if (beat.byte_valid && !len_overflow) begin
      blk_bytes[block_level] = beat.data_byte;
      block_level++;
      bytes_o++;
      msg_bits += 128'd8;
      if (msg_bits < 128'd8) len_overflow = 1'b1;
      if (block_level == 128) compress_block();
    end
    if (beat.last) begin
      blk_bytes[block_level] = s512_pkg::PadByte;
      block_level++;
      if (block_level > 112) begin
        while (block_level < 128) blk_bytes[block_level++] = '0;
        compress_block();
      end
      while (block_level < 112) blk_bytes[block_level++] = '0;
      for (int i = 0; i < 16; i++) blk_bytes[112+i] = msg_bits[127-8*i -: 8];
      compress_block();
      for (int k = 0; k < 8; k++) begin
        w.digest_word  = hash_state[k];
        w.word_index   = 3'(k);
        w.last_word    = (k == 7);
        w.length_error = len_overflow;
        digest_fifo.push_back(w);
      end
      digests_o++;
      start_message();
    end
  endfunction

  initial begin
    errors_o  = 0;
    pending_o = 0;
    digests_o = 0;
    bytes_o   = 0;
    start_message();
  end

  always @(posedge clk_i) begin
    s512_pkg::s512_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) absorb_beat(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_fifo.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("%0t: unexpected digest beat %h", $time, out_data_i);
        end else begin
          want = digest_fifo.pop_front();
          if (want.digest_word !== out_data_i.digest_word
              || want.word_index !== out_data_i.word_index
              || want.last_word !== out_data_i.last_word
              || want.length_error !== out_data_i.length_error) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: mismatch word %0d: expected %h/%b/%b got %h/%0d/%b/%b", $time,
                       want.word_index, want.digest_word, want.last_word, want.length_error,
                       out_data_i.digest_word, out_data_i.word_index, out_data_i.last_word,
                       out_data_i.length_error);
          end
        end
      end
    end
    pending_o = digest_fifo.size();
  end
endmodule

/* sim/sha512_hash_engine_tb.sv */
`timescale 1ns / 1ps

module sha512_hash_engine_tb;

  localparam int CycleLimit = 600000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  s512_pkg::s512_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  s512_pkg::s512_out_t out_data;
  int        errors, pending, digests, bytes_seen;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        beats_sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sha512_hash_engine DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  sha512_hash_engine_chk u_chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending), .digests_o(digests), .bytes_o(bytes_seen)
  );

  // receiver stall: cycle through free, light, heavy and periodic phases of equal length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count / 64) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= (cycle_count % 5) < 2;
    endcase
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic bv, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, byte_valid: bv, last: lst};
    do @(posedge clk_i); while (in_stall);
    burst_left--;
    beats_sent++;
  endtask

  // one message; the closing byte rides on the last beat or a finish-only beat follows
  task automatic send_message(input int len, input bit last_carries_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && last_carries_byte) send_beat(8'($urandom), 1'b1, 1'b1);
      else send_beat(8'($urandom), 1'b1, 1'b0);
    end
    if (len == 0 || !last_carries_byte) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len, pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: noise beat, empty message, extreme byte values, short messages
    send_beat(8'hFF, 1'b0, 1'b0);
    send_message(0, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b1);
    for (int i = 0; i < 8; i++) send_beat(8'h01 << i, 1'b1, i == 7);

    // random messages; a few cross the padding and block boundaries
    while (beats_sent < 50) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) len = $urandom_range(0, 24);
      else if (pick < 19) len = $urandom_range(108, 132);
      else len = $urandom_range(236, 260);
      send_message(len, 1'($urandom_range(0, 1)));
    end
    // boundary lengths around the length field and a full block
    send_message(111, 1'b1);
    send_message(112, 1'b0);
    send_message(128, 1'b1);
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d input beats (%0d message bytes), checked %0d digests of 8 words.",
             beats_sent, bytes_seen, digests);
    if (errors == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
